### rtl/core/sensor_data_message_framer_defines.svh
// Assertion macros shared by the framer RTL.
`ifndef SENSOR_DATA_MESSAGE_FRAMER_DEFINES_SVH
`define SENSOR_DATA_MESSAGE_FRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SDMF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdmf assertion failed");

// Next-cycle implication, disabled during reset.
`define SDMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdmf assertion failed");

`endif

### rtl/core/sdmf_pkg.sv
`timescale 1ns / 1ps

package sdmf_pkg;

   localparam logic [7:0] HdrBase = 8'hC0;
   localparam logic [7:0] ChkSeed = 8'hFF;
   localparam int         MaxWords = 3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [2:0] mode;
      logic [2:0] size_code;
   } item_type;

   // Words produced by one item; word 0 goes out first.
   typedef struct packed {
      logic [MaxWords-1:0][7:0] bytes;
      logic [MaxWords-1:0]      last;
      logic [1:0]               count;
   } frame_type;

endpackage

### rtl/core/sdmf_in_reg.sv
`timescale 1ns / 1ps

module sdmf_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sdmf_pkg::item_type req_item,
   input  logic              take,
   output logic              item_valid,
   output sdmf_pkg::item_type item
);

   logic               valid_ff, valid_in;
   sdmf_pkg::item_type item_ff, item_in;

   assign req_ready  = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

### rtl/core/sdmf_framer.sv
`timescale 1ns / 1ps
`include "sensor_data_message_framer_defines.svh"

module sdmf_framer (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  sdmf_pkg::item_type  item,
   output sdmf_pkg::frame_type frame
);

   logic [6:0] byte_count_ff, byte_count_in;
   logic [7:0] check_ff, check_in;
   logic [2:0] size_ff, size_in;

   logic       open;
   logic [2:0] size_eff;
   logic [7:0] hdr, chk_base, chk_new, cnt_new, target;
   logic       done;

   always_comb begin
      open     = (byte_count_ff == 7'd0);
      size_eff = open ? item.size_code : size_ff;
      hdr      = sdmf_pkg::HdrBase | {2'b00, item.size_code, item.mode};
      chk_base = open ? (sdmf_pkg::ChkSeed ^ hdr) : check_ff;
      chk_new  = chk_base ^ item.data_byte;
      cnt_new  = {1'b0, byte_count_ff} + 8'd1;
      target   = 8'd1 << size_eff;
      done     = (cnt_new >= target);

      frame = '0;
      if (open) begin
         frame.bytes[0] = hdr;
         frame.bytes[1] = item.data_byte;
         frame.bytes[2] = chk_new;
         frame.last[2]  = done;
         frame.count    = done ? 2'd3 : 2'd2;
      end else begin
         frame.bytes[0] = item.data_byte;
         frame.bytes[1] = chk_new;
         frame.last[1]  = done;
         frame.count    = done ? 2'd2 : 2'd1;
      end

      byte_count_in = byte_count_ff;
      check_in      = check_ff;
      size_in       = size_ff;
      if (take) begin
         size_in       = size_eff;
         byte_count_in = done ? 7'd0 : cnt_new[6:0];
         check_in      = done ? 8'd0 : chk_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 7'd0;
         check_ff      <= 8'd0;
         size_ff       <= 3'd0;
      end else begin
         byte_count_ff <= byte_count_in;
         check_ff      <= check_in;
         size_ff       <= size_in;
      end
   end

   `SDMF_ASSERT_NEXT(a_close_clears, clock, reset, take && done,
      byte_count_ff == 7'd0 && check_ff == 8'd0)
   `SDMF_ASSERT_NEXT(a_idle_holds, clock, reset, !take,
      $stable(byte_count_ff) && $stable(size_ff) && $stable(check_ff))
   `SDMF_ASSERT_NEXT(a_open_latches, clock, reset, take && open,
      size_ff == $past(item.size_code))
   `SDMF_ASSERT_NOW(a_last_on_close, clock, reset, take,
      done == (frame.last != '0))

endmodule

### rtl/core/sdmf_serializer.sv
`timescale 1ns / 1ps

module sdmf_serializer (
   input  logic                clock,
   input  logic                reset,
   input  sdmf_pkg::frame_type frame,
   input  logic                load,
   output logic                can_load,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last
);

   logic [1:0]                         cnt_ff, cnt_in;
   logic [sdmf_pkg::MaxWords-1:0][7:0] bytes_ff, bytes_in;
   logic [sdmf_pkg::MaxWords-1:0]      last_ff, last_in;
   logic                               pop;

   assign rsp_valid    = (cnt_ff != 2'd0);
   assign rsp_out_byte = bytes_ff[0];
   assign rsp_last     = last_ff[0];
   assign pop          = rsp_valid && rsp_ready;
   assign can_load     = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ready);

   always_comb begin
      cnt_in   = cnt_ff;
      bytes_in = bytes_ff;
      last_in  = last_ff;
      if (load) begin
         cnt_in   = frame.count;
         bytes_in = frame.bytes;
         last_in  = frame.last;
      end else if (pop) begin
         // advance the queue by one word
         cnt_in   = cnt_ff - 2'd1;
         bytes_in = {8'd0, bytes_ff[2], bytes_ff[1]};
         last_in  = {1'b0, last_ff[2], last_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      bytes_ff <= bytes_in;
      last_ff  <= last_in;
   end

endmodule

### rtl/core/sensor_data_message_framer.sv
`timescale 1ns / 1ps
// Channel   Ports                                          Direction
// req       req_valid/ready, data_byte, mode, size_code    in
// rsp       rsp_valid/ready, out_byte, last                out
//
// The framer turns each item into 1 to 3 words, so the rate is set by the
// one-word-per-cycle output queue while rsp_ready is high: one item per cycle
// mid-message, plus a word for the header and one for the checksum of each message.
// An accepted item passes through the input register and then the output queue.
// Synchronous active-high reset empties both registers and closes any open message.
// A stalled rsp side holds the queue; the input register keeps taking one item
// while the queue still drains its final word.

module sensor_data_message_framer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic [2:0] req_mode,
   input  logic [2:0] req_size_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   sdmf_pkg::item_type  req_item, item;
   sdmf_pkg::frame_type frame;
   logic                item_valid, can_load, take;

   assign req_item.data_byte = req_data_byte;
   assign req_item.mode      = req_mode;
   assign req_item.size_code = req_size_code;

   // hand the held item to the framer once the queue has room for its words
   assign take = item_valid && can_load;

   sdmf_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   // header, checksum and byte count of the open message
   sdmf_framer u_framer (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .item  (item),
      .frame (frame)
   );

   // drain the words of one item, one per cycle while rsp_ready is high
   sdmf_serializer u_serializer (
      .clock        (clock),
      .reset        (reset),
      .frame        (frame),
      .load         (take),
      .can_load     (can_load),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

### bench/sensor_data_message_framer_checker.sv
`timescale 1ns / 1ps

module sensor_data_message_framer_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic [2:0] req_mode,
   input  logic [2:0] req_size_code,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_last,
   output int         fail_count,
   output int         pending,
   output int         words_seen,
   output int         messages_closed
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } link_word_type;

   link_word_type frame_words_q[$];
   link_word_type want;

   // Framer state as seen from outside: bytes taken, XOR sum, size of the open message.
   logic [7:0] open_count = 8'd0;
   logic [7:0] check_acc  = 8'd0;
   logic [2:0] open_size  = 3'd0;

   int errs   = 0;
   int seen   = 0;
   int closed = 0;

   initial begin
      fail_count      = 0;
      pending         = 0;
      words_seen      = 0;
      messages_closed = 0;
   end

   task automatic queue_word(input logic [7:0] b, input logic l);
      link_word_type w;
      w.out_byte = b;
      w.last     = l;
      frame_words_q.push_back(w);
   endtask

   task automatic frame_byte(input logic [7:0] d, input logic [2:0] m, input logic [2:0] s);
      logic [7:0] hdr;
      logic [7:0] target;
      if (open_count == 8'd0) begin
         hdr       = sdmf_pkg::HdrBase | {2'b00, s, 3'b000} | {5'b00000, m};
         open_size = s;
         check_acc = sdmf_pkg::ChkSeed ^ hdr;
         queue_word(hdr, 1'b0);
      end
      queue_word(d, 1'b0);
      check_acc  = check_acc ^ d;
      open_count = open_count + 8'd1;
      target     = 8'd1 << open_size;
      if (open_count >= target) begin
         queue_word(check_acc, 1'b1);
         open_count = 8'd0;
         check_acc  = 8'd0;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            frame_byte(req_data_byte, req_mode, req_size_code);
         end
         if (rsp_valid && rsp_ready) begin
            seen = seen + 1;
            if (rsp_last === 1'b1) begin
               closed = closed + 1;
            end
            if (frame_words_q.size() == 0) begin
               $error("unexpected word: out_byte %02h last %0b", rsp_out_byte, rsp_last);
               errs = errs + 1;
            end else begin
               want = frame_words_q.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_out_byte);
                  errs = errs + 1;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  errs = errs + 1;
               end
            end
         end
      end
      fail_count      <= errs;
      pending         <= frame_words_q.size();
      words_seen      <= seen;
      messages_closed <= closed;
   end

endmodule

### bench/sensor_data_message_framer_tb.sv
`timescale 1ns / 1ps

module sensor_data_message_framer_tb;

   // Generous ceiling for the watchdog.
   localparam int CycleLimit = 200000;
   // Receiver hold-off long enough to fill every stage of the framer.
   localparam int HoldCycles = 300;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic [2:0] req_mode      = 3'd0;
   logic [2:0] req_size_code = 3'd0;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   int fail_count;
   int pending;
   int words_seen;
   int messages_closed;

   int cycle_count  = 0;
   int items_sent   = 0;
   int burst_left   = 0;
   bit hold_pace    = 1'b0;
   int press_asked  = 0;
   int press_served = 0;

   sensor_data_message_framer u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_mode      (req_mode),
      .req_size_code (req_size_code),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last)
   );

   sensor_data_message_framer_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_mode        (req_mode),
      .req_size_code   (req_size_code),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last),
      .fail_count      (fail_count),
      .pending         (pending),
      .words_seen      (words_seen),
      .messages_closed (messages_closed)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offer one input word and hold it until accepted. Called and left at a falling edge.
   // Bursts of random length, with random gaps between them unless pacing is held off.
   task automatic push_byte(input logic [7:0] d, input logic [2:0] m, input logic [2:0] s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = $urandom_range(0, 6);
         if (!hold_pace && gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left    = burst_left - 1;
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_mode      <= m;
      req_size_code <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent = items_sent + 1;
      @(negedge clock);
   endtask

   // Send a whole message of random bytes; later words carry random mode and size,
   // which the framer must ignore.
   task automatic random_message(input logic [2:0] s);
      int len;
      len = 1 << s;
      for (int i = 0; i < len; i++) begin
         if (i == 0) begin
            push_byte(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), s);
         end else begin
            push_byte(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                      3'($urandom_range(0, 7)));
         end
      end
   endtask

   // Receiver: drop ready on a randomly chosen pattern, and hold it
   // low for a long stretch whenever the sender asks for back pressure.
   initial begin
      int rx_mode;
      int phase_cnt;
      int hold_left;
      rx_mode   = 0;
      phase_cnt = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (press_asked != press_served) begin
            press_served = press_asked;
            hold_left    = HoldCycles;
         end
         phase_cnt = phase_cnt + 1;
         if (phase_cnt % 64 == 0) begin
            rx_mode = $urandom_range(0, 3);
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 7) != 0);
               default: rsp_ready <= ((phase_cnt % 16) < 10);
            endcase
         end
      end
   end

   initial begin
      int rand_items;
      int pick;
      bit long_done;
      bit press_done;
      logic [2:0] s;
      rand_items = 0;
      long_done  = 1'b0;
      press_done = 1'b0;

      // Hold reset, then release it at a falling edge.
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // One-byte messages at the extremes of data and mode.
      push_byte(8'h00, 3'd0, 3'd0);
      push_byte(8'hFF, 3'd7, 3'd0);
      push_byte(8'h80, 3'd1, 3'd0);
      // Two-byte messages; mode and size on the second word must be ignored.
      push_byte(8'hAA, 3'd5, 3'd1);
      push_byte(8'h55, 3'd2, 3'd7);
      push_byte(8'h01, 3'd6, 3'd1);
      push_byte(8'h7F, 3'd0, 3'd0);
      // Four-byte message with junk mode and size on the later words.
      push_byte(8'h00, 3'd3, 3'd2);
      push_byte(8'hFF, 3'd7, 3'd0);
      push_byte(8'h0F, 3'd0, 3'd7);
      push_byte(8'hF0, 3'd7, 3'd7);
      // Eight-byte message.
      push_byte(8'h12, 3'd4, 3'd3);
      for (int i = 1; i < 8; i++) begin
         push_byte(8'hFF ^ i[7:0], i[2:0], ~i[2:0]);
      end

      // Random messages, mostly short; one full 128-byte message and one
      // stretch of back pressure with the sender running flat out.
      while (rand_items < 150) begin
         if (!press_done && rand_items >= 8) begin
            press_done  = 1'b1;
            hold_pace   = 1'b1;
            press_asked = press_asked + 1;
            random_message(3'd4);
            hold_pace  = 1'b0;
            rand_items = rand_items + 16;
         end else if (!long_done && rand_items >= 24) begin
            long_done = 1'b1;
            random_message(3'd7);
            rand_items = rand_items + 128;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               s = 3'($urandom_range(0, 2));
            end else if (pick < 95) begin
               s = 3'd3;
            end else begin
               s = 3'($urandom_range(4, 6));
            end
            random_message(s);
            rand_items = rand_items + (1 << s);
         end
      end

      // Drain: drop valid, wait until every predicted word has come out.
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("Sent %0d input words; checked %0d link words and %0d closed messages.",
               items_sent, words_seen, messages_closed);
      $display("Sizes 1 to 128 bytes, ignored mode and size on later words, one long hold-off.");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
